/* design/uhd_pkg.sv */
// Shared types, character constants and sizes for the URL hex escape decoder.
package uhd_pkg;

	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_BSL    = 8'h5c;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CASE_MASK = 8'hdf;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] HEX_TEN   = 8'd10;

	localparam int QUEUE_DEPTH = 4;
	localparam int BUNDLE_MAX  = 4;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PCT,
		PH_PCT_D,
		PH_BSL,
		PH_BSL_X,
		PH_BSL_X_D
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic [BUNDLE_MAX-1:0][7:0] data;
		logic [2:0]                 cnt;
		logic                       last;
	} bundle_t;

endpackage

/* design/url_hex_escape_decoder.sv */
// Top level of the URL percent and backslash-x hex escape decoder.
// A byte's first result passes the bundle queue, then the output register; output stall delays it.
// One byte in and one result out per cycle unless stalled; an item yields 0 to 4 results.
// Results drain through a bundle queue of DEPTH entries; input stalls only while it is full.
// Reset: arst_n clears escape phase, queue pointers and the output valid at once.
module url_hex_escape_decoder import uhd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic    acc;
	logic    push;
	logic    pop;
	logic    full;
	logic    not_empty;
	bundle_t wr_bundle;
	bundle_t head;

	assign item_stall = full;
	assign acc        = item_valid && !full;

	uhd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.item   (item),
		.bundle (wr_bundle),
		.push   (push)
	);

	uhd_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (wr_bundle),
		.pop       (pop),
		.rd_data   (head),
		.not_empty (not_empty),
		.full      (full)
	);

	uhd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (not_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

endmodule

/* design/uhd_front.sv */
// Front end: tracks escape phase and turns each input byte into a bundle of output bytes.
module uhd_front import uhd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     acc,
	input  in_item_t item,
	output bundle_t  bundle,
	output logic     push
);

	phase_t     phase_q;
	logic [7:0] held_q;

	phase_t     ph;
	logic [7:0] hd;
	bundle_t    bd;
	logic       fresh;
	logic       hex;
	logic [7:0] b;

	function automatic bundle_t append(bundle_t src, logic [7:0] v);
		bundle_t r;
		r = src;
		r.data[src.cnt[1:0]] = v;
		r.cnt = src.cnt + 3'd1;
		return r;
	endfunction

	function automatic bundle_t flush(bundle_t src, phase_t p, logic [7:0] h);
		bundle_t r;
		r = src;
		case (p)
			PH_PCT: begin
				r = append(r, CH_PCT);
			end
			PH_PCT_D: begin
				r = append(r, CH_PCT);
				r = append(r, h);
			end
			PH_BSL: begin
				r = append(r, CH_BSL);
			end
			PH_BSL_X: begin
				r = append(r, CH_BSL);
				r = append(r, CH_X);
			end
			PH_BSL_X_D: begin
				r = append(r, CH_BSL);
				r = append(r, CH_X);
				r = append(r, h);
			end
			default: begin
				r = src;
			end
		endcase
		return r;
	endfunction

	function automatic logic [3:0] nibble(logic [7:0] c);
		logic [7:0] t;
		if (c >= CH_A) begin
			t = (c & CASE_MASK) - CH_A + HEX_TEN;
		end else begin
			t = c - CH_0;
		end
		return t[3:0];
	endfunction

	assign b = item.in_byte;

	always_comb begin
		bd    = '0;
		ph    = phase_q;
		hd    = held_q;
		fresh = 1'b0;
		hex   = b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
		case (phase_q)
			PH_PCT, PH_BSL_X: begin
				if (hex) begin
					hd = b;
					ph = (phase_q == PH_PCT) ? PH_PCT_D : PH_BSL_X_D;
				end else begin
					bd    = flush(bd, phase_q, held_q);
					fresh = 1'b1;
				end
			end
			PH_PCT_D, PH_BSL_X_D: begin
				if (hex) begin
					bd = append(bd, {nibble(held_q), nibble(b)});
					ph = PH_IDLE;
					hd = '0;
				end else begin
					bd    = flush(bd, phase_q, held_q);
					fresh = 1'b1;
				end
			end
			PH_BSL: begin
				if (b == CH_X) begin
					ph = PH_BSL_X;
				end else begin
					bd    = flush(bd, phase_q, held_q);
					fresh = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			ph = PH_IDLE;
			hd = '0;
			if (b == CH_PCT) begin
				ph = PH_PCT;
			end else if (b == CH_BSL) begin
				ph = PH_BSL;
			end else begin
				bd = append(bd, b);
			end
		end
		if (item.in_last) begin
			bd      = flush(bd, ph, hd);
			ph      = PH_IDLE;
			hd      = '0;
			bd.last = 1'b1;
		end
	end

	assign bundle = bd;
	assign push   = acc && (bd.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (acc) begin
			phase_q <= ph;
			held_q  <= hd;
		end
	end

endmodule

/* design/uhd_queue.sv */
// Bundle queue between the front end and the output serializer.
module uhd_queue import uhd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wr_data,
	input  logic    pop,
	output bundle_t rd_data,
	output logic    not_empty,
	output logic    full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   count_q;

	function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign rd_data   = mem_q[rd_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* design/uhd_back.sv */
// Back end: serializes queued bundles into single result bytes through an output register.
module uhd_back import uhd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bundle_t   head,
	input  logic      head_valid,
	output logic      pop,
	output logic      result_valid,
	output out_item_t result,
	input  logic      result_stall
);

	logic [1:0] idx_q;
	logic       valid_q;
	out_item_t  res_q;
	logic       load;
	logic       at_end;

	assign load   = head_valid && (!valid_q || !result_stall);
	assign at_end = ({1'b0, idx_q} == (head.cnt - 3'd1));
	assign pop    = load && at_end;

	assign result_valid = valid_q;
	assign result       = res_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte <= head.data[idx_q];
			res_q.out_last <= head.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/uhd_checker.sv */
// Port-level checks for the URL hex escape decoder and their bind to the top level.
module uhd_checker import uhd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	a_full_means_output: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("queue full while output register empty");

	a_empty_output_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |=> !item_stall)
		else $error("input stalled right after output was empty");

endmodule

bind url_hex_escape_decoder uhd_checker u_chk (.*);

/* tb/sv/tb_url_hex_escape_decoder.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the URL hex escape decoder: directed and random text streams.
module tb_url_hex_escape_decoder;
	import uhd_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	in_item_t  pending_chars[$];
	out_item_t decoded_chars[$];
	out_item_t step_chars[$];
	phase_t    dec_phase = PH_IDLE;
	logic [7:0] dec_held = '0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        errors = 0;

	url_hex_escape_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	function automatic bit is_hex_char(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic [3:0] hex_value(logic [7:0] c);
		logic [7:0] v;
		if (c >= CH_A) begin
			v = (c & CASE_MASK) - CH_A + HEX_TEN;
		end else begin
			v = c - CH_0;
		end
		return v[3:0];
	endfunction

	function automatic void emit_char(logic [7:0] b);
		out_item_t o;
		o.out_byte = b;
		o.out_last = 1'b0;
		step_chars.push_back(o);
	endfunction

	function automatic void flush_held();
		case (dec_phase)
			PH_PCT: emit_char(CH_PCT);
			PH_PCT_D: begin
				emit_char(CH_PCT);
				emit_char(dec_held);
			end
			PH_BSL: emit_char(CH_BSL);
			PH_BSL_X: begin
				emit_char(CH_BSL);
				emit_char(CH_X);
			end
			PH_BSL_X_D: begin
				emit_char(CH_BSL);
				emit_char(CH_X);
				emit_char(dec_held);
			end
			default: ;
		endcase
		dec_phase = PH_IDLE;
		dec_held = '0;
	endfunction

	function automatic void decode_step(in_item_t it);
		logic [7:0] b;
		bit fresh;
		b = it.in_byte;
		fresh = 1'b0;
		step_chars.delete();
		case (dec_phase)
			PH_PCT, PH_BSL_X: begin
				if (is_hex_char(b)) begin
					dec_held = b;
					dec_phase = (dec_phase == PH_PCT) ? PH_PCT_D : PH_BSL_X_D;
				end else begin
					flush_held();
					fresh = 1'b1;
				end
			end
			PH_PCT_D, PH_BSL_X_D: begin
				if (is_hex_char(b)) begin
					emit_char({hex_value(dec_held), hex_value(b)});
					dec_phase = PH_IDLE;
					dec_held = '0;
				end else begin
					flush_held();
					fresh = 1'b1;
				end
			end
			PH_BSL: begin
				if (b == CH_X) begin
					dec_phase = PH_BSL_X;
				end else begin
					flush_held();
					fresh = 1'b1;
				end
			end
			default: begin
				dec_phase = PH_IDLE;
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			if (b == CH_PCT) begin
				dec_phase = PH_PCT;
			end else if (b == CH_BSL) begin
				dec_phase = PH_BSL;
			end else begin
				emit_char(b);
			end
		end
		if (it.in_last) begin
			flush_held();
			if (step_chars.size() != 0) begin
				step_chars[step_chars.size()-1].out_last = 1'b1;
			end
		end
		foreach (step_chars[i]) begin
			decoded_chars.push_back(step_chars[i]);
		end
	endfunction

	function automatic void push_char(logic [7:0] b, logic last);
		in_item_t it;
		it.in_byte = b;
		it.in_last = last;
		pending_chars.push_back(it);
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i], i == s.len() - 1);
		end
	endfunction

	function automatic logic [7:0] rand_hex_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(21)];
	endfunction

	function automatic int append_random_string();
		int tokens;
		int added;
		int n0;
		tokens = $urandom_range(1, 5);
		n0 = pending_chars.size();
		for (int t = 0; t < tokens; t++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					if ($urandom_range(1)) begin
						push_char(CH_PCT, 1'b0);
					end else begin
						push_char(CH_BSL, 1'b0);
						push_char(CH_X, 1'b0);
					end
					push_char(rand_hex_char(), 1'b0);
					push_char(rand_hex_char(), 1'b0);
				end
				4, 5: begin
					case ($urandom_range(4))
						0: push_char(CH_PCT, 1'b0);
						1: begin
							push_char(CH_PCT, 1'b0);
							push_char(rand_hex_char(), 1'b0);
						end
						2: push_char(CH_BSL, 1'b0);
						3: begin
							push_char(CH_BSL, 1'b0);
							push_char(CH_X, 1'b0);
						end
						default: begin
							push_char(CH_BSL, 1'b0);
							push_char(CH_X, 1'b0);
							push_char(rand_hex_char(), 1'b0);
						end
					endcase
					if ($urandom_range(2) != 0) begin
						push_char(8'($urandom_range(255)), 1'b0);
					end
				end
				default: push_char(8'($urandom_range(255)), 1'b0);
			endcase
		end
		added = pending_chars.size() - n0;
		pending_chars[pending_chars.size()-1].in_last = 1'b1;
		return added;
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_chars.size() != 0 || item_valid || decoded_chars.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				decode_step(item);
			end
			if (!item_valid || !item_stall) begin
				if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item_valid <= 1'b1;
					item <= pending_chars.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (decoded_chars.size() == 0) begin
				$error("out_byte: expected none, got %h", result.out_byte);
				errors++;
			end else begin
				want = decoded_chars.pop_front();
				if (result.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, result.out_byte);
					errors++;
				end
				if (result.out_last !== want.out_last) begin
					$error("out_last: expected %b, got %b", want.out_last, result.out_last);
					errors++;
				end
			end
		end
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		int added;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 83 : 0;
			recv_stall_pct = (mode == 0) ? 83 : (mode == 1) ? 18 : 0;
			if (mode == 0) begin
				push_char(8'h00, 1'b1);
				push_char(8'hff, 1'b1);
				push_text("%4a");
				push_text("\\xF0");
				push_text("\\x4g");
				push_text("%4%");
				push_text("\\");
				push_text("%");
				push_text("\\q");
				push_text("\\x");
				push_text("%A9");
			end
			added = 0;
			while (added < 45) begin
				added += append_random_string();
			end
			// hold the sender until every result of this pass is out
			wait_drained();
		end
		repeat (20) @(negedge clk);
		if (decoded_chars.size() != 0) begin
			$error("out_byte: expected %h, got none", decoded_chars[0].out_byte);
			errors++;
		end
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* url_hex_escape_decoder.f */
design/uhd_pkg.sv
design/uhd_front.sv
design/uhd_queue.sv
design/uhd_back.sv
design/url_hex_escape_decoder.sv
design/uhd_checker.sv
tb/sv/tb_url_hex_escape_decoder.sv
